FILE: src/tcc_pkg.sv
// Shared constants, state type and lookup functions for the tick count to calendar converter.
package tcc_pkg;

    localparam int TICK_W   = 49;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int DOY_W    = 9;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MS_W     = 10;

    localparam int MAX_YEAR = 9999;

    localparam int REM_W = 27;
    localparam int CNT_W = $clog2(TICK_W);
    localparam int BIT_W = 3;
    localparam int QW    = 6;

    localparam logic [REM_W:0]    MS_PER_DAY = 28'd86_400_000;
    localparam logic [TICK_W-1:0] DAY_LIMIT  =
        TICK_W'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_RANGE,
        ST_Y400,
        ST_Y100,
        ST_Y4,
        ST_Y1,
        ST_HOUR,
        ST_MIN,
        ST_SEC,
        ST_DONE
    } t_state;

    function automatic logic [REM_W-1:0] f_div_base(input t_state s);
        logic [REM_W-1:0] d;
        case (s)
            ST_Y400: d = 27'd146_097;
            ST_Y100: d = 27'd36_524;
            ST_Y4:   d = 27'd1_461;
            ST_Y1:   d = 27'd365;
            ST_HOUR: d = 27'd3_600_000;
            ST_MIN:  d = 27'd60_000;
            ST_SEC:  d = 27'd1_000;
            default: d = '0;
        endcase
        return d;
    endfunction

    // top quotient bit of each phase; 100-year and 1-year phases saturate at 3
    function automatic logic [BIT_W-1:0] f_top_bit(input t_state s);
        logic [BIT_W-1:0] b;
        case (s)
            ST_Y400: b = 3'd4;
            ST_Y100: b = 3'd1;
            ST_Y4:   b = 3'd4;
            ST_Y1:   b = 3'd1;
            ST_HOUR: b = 3'd4;
            ST_MIN:  b = 3'd5;
            ST_SEC:  b = 3'd5;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [DOY_W-1:0] f_cum(input logic leap, input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] c;
        unique case (idx)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd31;
            4'd2:  c = leap ? 9'd60  : 9'd59;
            4'd3:  c = leap ? 9'd91  : 9'd90;
            4'd4:  c = leap ? 9'd121 : 9'd120;
            4'd5:  c = leap ? 9'd152 : 9'd151;
            4'd6:  c = leap ? 9'd182 : 9'd181;
            4'd7:  c = leap ? 9'd213 : 9'd212;
            4'd8:  c = leap ? 9'd244 : 9'd243;
            4'd9:  c = leap ? 9'd274 : 9'd273;
            4'd10: c = leap ? 9'd305 : 9'd304;
            4'd11: c = leap ? 9'd335 : 9'd334;
            default: c = leap ? 9'd366 : 9'd365;
        endcase
        return c;
    endfunction

    function automatic logic [MONTH_W-1:0] f_month(input logic leap, input logic [DOY_W-1:0] doy0);
        logic [MONTH_W-1:0] m;
        m = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (doy0 >= f_cum(leap, MONTH_W'(k))) begin
                m = m + 4'd1;
            end
        end
        return m;
    endfunction

endpackage

FILE: src/tick_count_to_calendar.sv
// Millisecond tick count to Gregorian calendar fields, bit-serial restoring division.
// Steps: day split, range check, then (in range only) the year, hour, minute and second
// phases before the result is registered. One transaction at a time: the next input is
// accepted once the result is registered and the converter is back in idle. The divider
// retires one quotient bit per cycle; the done state waits while the output is held.
// Reset (synchronous, active low) returns to idle and clears the output valid flag.
module tick_count_to_calendar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcc_pkg::TICK_W-1:0]    i_tick_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcc_pkg::YEAR_W-1:0]    o_year,
    output logic [tcc_pkg::MONTH_W-1:0]   o_month,
    output logic [tcc_pkg::DOM_W-1:0]     o_day_of_month,
    output logic [tcc_pkg::DOY_W-1:0]     o_day_of_year,
    output logic [tcc_pkg::HOUR_W-1:0]    o_hour,
    output logic [tcc_pkg::MINUTE_W-1:0]  o_minute,
    output logic [tcc_pkg::SECOND_W-1:0]  o_second,
    output logic [tcc_pkg::MS_W-1:0]      o_millisecond,
    output logic                          o_leap_year,
    output logic                          o_out_of_range
);
    import tcc_pkg::*;

    t_state r_state, n_state;

    logic [REM_W-1:0]  r_rem, n_rem;
    logic [TICK_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [REM_W-1:0]  r_n, n_n;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [QW-1:0]     r_q, n_q;
    logic [4:0]        r_q400, n_q400;
    logic [1:0]        r_q100, n_q100;
    logic [4:0]        r_q4, n_q4;
    logic [1:0]        r_q1, n_q1;
    logic [DOY_W-1:0]  r_doy, n_doy;
    logic [HOUR_W-1:0] r_hr, n_hr;
    logic [MINUTE_W-1:0] r_mn, n_mn;
    logic [SECOND_W-1:0] r_sc, n_sc;
    logic              r_oor, n_oor;
    logic              r_ovalid, n_ovalid;

    logic [YEAR_W-1:0]   r_year, n_year;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [DOM_W-1:0]    r_dom, n_dom;
    logic [DOY_W-1:0]    r_doy_o, n_doy_o;
    logic [HOUR_W-1:0]   r_hour, n_hour;
    logic [MINUTE_W-1:0] r_minute, n_minute;
    logic [SECOND_W-1:0] r_second, n_second;
    logic [MS_W-1:0]     r_ms, n_ms;
    logic                r_leap, n_leap;
    logic                r_range, n_range;

    logic [REM_W:0]      t_day;
    logic                day_ge;
    logic                day_oor;
    logic [REM_W-1:0]    div_val;
    logic                div_ge;
    logic [REM_W-1:0]    n_step;
    logic [QW-1:0]       q_next;
    logic                out_free;
    logic                phase_end;
    logic                leap_calc;
    logic [YEAR_W-1:0]   year_calc;
    logic [MONTH_W-1:0]  month_calc;

    assign t_day     = {r_rem, r_sh[TICK_W-1]};
    assign day_ge    = t_day >= MS_PER_DAY;
    assign day_oor   = r_sh >= DAY_LIMIT;
    assign div_val   = f_div_base(r_state) << r_bit;
    assign div_ge    = r_n >= div_val;
    assign n_step    = div_ge ? (r_n - div_val) : r_n;
    assign q_next    = {r_q[QW-2:0], div_ge};
    assign out_free  = !r_ovalid || i_out_ready;
    assign phase_end = (r_bit == '0);

    assign leap_calc  = (r_q1 == 2'd3) && ((r_q4 != 5'd24) || (r_q100 == 2'd3));
    assign year_calc  = YEAR_W'(r_q400) * 14'd400 + YEAR_W'(r_q100) * 14'd100
                      + YEAR_W'(r_q4) * 14'd4 + YEAR_W'(r_q1) + 14'd1;
    assign month_calc = f_month(leap_calc, r_doy);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_DAY;
            ST_DAY:   if (r_cnt == '0) n_state = ST_RANGE;
            ST_RANGE: n_state = day_oor ? ST_DONE : ST_Y400;
            ST_Y400:  if (phase_end) n_state = ST_Y100;
            ST_Y100:  if (phase_end) n_state = ST_Y4;
            ST_Y4:    if (phase_end) n_state = ST_Y1;
            ST_Y1:    if (phase_end) n_state = ST_HOUR;
            ST_HOUR:  if (phase_end) n_state = ST_MIN;
            ST_MIN:   if (phase_end) n_state = ST_SEC;
            ST_SEC:   if (phase_end) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
    end

    always_comb begin
        n_rem    = r_rem;
        n_sh     = r_sh;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_bit    = r_bit;
        n_q      = r_q;
        n_q400   = r_q400;
        n_q100   = r_q100;
        n_q4     = r_q4;
        n_q1     = r_q1;
        n_doy    = r_doy;
        n_hr     = r_hr;
        n_mn     = r_mn;
        n_sc     = r_sc;
        n_oor    = r_oor;
        n_ovalid = r_ovalid;
        n_year   = r_year;
        n_month  = r_month;
        n_dom    = r_dom;
        n_doy_o  = r_doy_o;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_ms     = r_ms;
        n_leap   = r_leap;
        n_range  = r_range;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sh  = i_tick_count;
                    n_rem = '0;
                    n_cnt = CNT_W'(TICK_W - 1);
                end
            end
            ST_DAY: begin
                n_rem = day_ge ? REM_W'(t_day - MS_PER_DAY) : t_day[REM_W-1:0];
                n_sh  = {r_sh[TICK_W-2:0], day_ge};
                n_cnt = r_cnt - 1'b1;
            end
            ST_RANGE: begin
                n_oor = day_oor;
                n_n   = r_sh[REM_W-1:0];
                n_bit = f_top_bit(ST_Y400);
                n_q   = '0;
            end
            ST_Y400, ST_Y100, ST_Y4, ST_Y1, ST_HOUR, ST_MIN, ST_SEC: begin
                n_n   = n_step;
                n_q   = q_next;
                n_bit = r_bit - 1'b1;
                if (phase_end) begin
                    n_q   = '0;
                    n_bit = f_top_bit(n_state);
                    unique case (r_state)
                        ST_Y400: n_q400 = q_next[4:0];
                        ST_Y100: n_q100 = q_next[1:0];
                        ST_Y4:   n_q4   = q_next[4:0];
                        ST_Y1: begin
                            n_q1  = q_next[1:0];
                            n_doy = n_step[DOY_W-1:0];
                            n_n   = r_rem;
                        end
                        ST_HOUR: n_hr = q_next[HOUR_W-1:0];
                        ST_MIN:  n_mn = q_next[MINUTE_W-1:0];
                        default: n_sc = q_next[SECOND_W-1:0];
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_range  = r_oor;
                    if (r_oor) begin
                        n_year   = '0;
                        n_month  = '0;
                        n_dom    = '0;
                        n_doy_o  = '0;
                        n_hour   = '0;
                        n_minute = '0;
                        n_second = '0;
                        n_ms     = '0;
                        n_leap   = 1'b0;
                    end else begin
                        n_year   = year_calc;
                        n_month  = month_calc;
                        n_dom    = DOM_W'(r_doy - f_cum(leap_calc, month_calc - 4'd1) + 9'd1);
                        n_doy_o  = r_doy + 9'd1;
                        n_hour   = r_hr;
                        n_minute = r_mn;
                        n_second = r_sc;
                        n_ms     = r_n[MS_W-1:0];
                        n_leap   = leap_calc;
                    end
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_sh     <= n_sh;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_bit    <= n_bit;
        r_q      <= n_q;
        r_q400   <= n_q400;
        r_q100   <= n_q100;
        r_q4     <= n_q4;
        r_q1     <= n_q1;
        r_doy    <= n_doy;
        r_hr     <= n_hr;
        r_mn     <= n_mn;
        r_sc     <= n_sc;
        r_oor    <= n_oor;
        r_year   <= n_year;
        r_month  <= n_month;
        r_dom    <= n_dom;
        r_doy_o  <= n_doy_o;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
        r_ms     <= n_ms;
        r_leap   <= n_leap;
        r_range  <= n_range;
    end

    assign o_out_valid    = r_ovalid;
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;
    assign o_day_of_year  = r_doy_o;
    assign o_hour         = r_hour;
    assign o_minute       = r_minute;
    assign o_second       = r_second;
    assign o_millisecond  = r_ms;
    assign o_leap_year    = r_leap;
    assign o_out_of_range = r_range;

endmodule

FILE: src/tcc_checker.sv
// Port-level assertions for the tick count to calendar converter and their bind.
module tcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [13:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day_of_month,
    input logic [8:0]  o_day_of_year,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second,
    input logic [9:0]  o_millisecond,
    input logic        o_leap_year,
    input logic        o_out_of_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while conversion running");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
        (o_year == 14'd0 && o_month == 4'd0 && o_day_of_month == 5'd0 &&
         o_day_of_year == 9'd0 && o_hour == 5'd0 && o_minute == 6'd0 &&
         o_second == 6'd0 && o_millisecond == 10'd0 && !o_leap_year))
        else $error("out of range result with nonzero fields");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_of_range) |->
        (o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month >= 5'd1 &&
         o_day_of_year >= 9'd1 && o_day_of_year <= 9'd366 && o_hour <= 5'd23 &&
         o_minute <= 6'd59 && o_second <= 6'd59 && o_millisecond <= 10'd999 &&
         o_year >= 14'd1))
        else $error("calendar field out of legal range");

endmodule

bind tick_count_to_calendar tcc_checker u_tcc_checker (.*);

FILE: tb/tick_count_to_calendar_tb.sv
// Testbench for tick_count_to_calendar: directed and random tick counts, local predictor.
`timescale 1ns / 1ps

module tick_count_to_calendar_tb;

    import tcc_pkg::*;

    localparam longint unsigned MS_DAY     = 64'd86_400_000;
    localparam longint unsigned DAY_COUNT  =
        longint'(MAX_YEAR) * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam longint unsigned LAST_TICK  = DAY_COUNT * MS_DAY - 1;
    localparam int unsigned     HOLD_CYCLES = 400;
    localparam int unsigned     CYCLE_LIMIT = 1_000_000;
    localparam int unsigned     DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [DOY_W-1:0]    day_of_year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MS_W-1:0]     millisecond;
        logic                leap_year;
        logic                out_of_range;
    } t_cal;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [TICK_W-1:0]     i_tick_count = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [YEAR_W-1:0]     o_year;
    logic [MONTH_W-1:0]    o_month;
    logic [DOM_W-1:0]      o_day_of_month;
    logic [DOY_W-1:0]      o_day_of_year;
    logic [HOUR_W-1:0]     o_hour;
    logic [MINUTE_W-1:0]   o_minute;
    logic [SECOND_W-1:0]   o_second;
    logic [MS_W-1:0]       o_millisecond;
    logic                  o_leap_year;
    logic                  o_out_of_range;

    t_cal        pending_dates[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          bursts_on = 1'b1;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    tick_count_to_calendar dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_tick_count   (i_tick_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_day_of_year  (o_day_of_year),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_millisecond  (o_millisecond),
        .o_leap_year    (o_leap_year),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // days elapsed in the year before the first day of month m+1
    function automatic int unsigned days_before_month(input bit leap, input int unsigned m);
        int unsigned d;
        case (m)
            0:       d = 0;
            1:       d = 31;
            2:       d = 59;
            3:       d = 90;
            4:       d = 120;
            5:       d = 151;
            6:       d = 181;
            7:       d = 212;
            8:       d = 243;
            9:       d = 273;
            10:      d = 304;
            11:      d = 334;
            default: d = 365;
        endcase
        if (leap && m >= 2) begin
            d = d + 1;
        end
        return d;
    endfunction

    function automatic t_cal calendar_of(input logic [TICK_W-1:0] ticks);
        t_cal            r;
        longint unsigned days;
        longint unsigned tod;
        int unsigned     n;
        int unsigned     q400;
        int unsigned     q100;
        int unsigned     q4;
        int unsigned     q1;
        int unsigned     mon;
        bit              leap;
        r = '0;
        days = longint'(ticks) / MS_DAY;
        tod = longint'(ticks) % MS_DAY;
        if (days >= DAY_COUNT) begin
            r.out_of_range = 1'b1;
            return r;
        end
        n = int'(days);
        q400 = n / 146_097;
        n = n - q400 * 146_097;
        q100 = n / 36_524;
        if (q100 == 4) begin
            q100 = 3;
        end
        n = n - q100 * 36_524;
        q4 = n / 1_461;
        n = n - q4 * 1_461;
        q1 = n / 365;
        if (q1 == 4) begin
            q1 = 3;
        end
        n = n - q1 * 365;
        leap = (q1 == 3) && (q4 != 24 || q100 == 3);
        mon = 1;
        while (mon < 12 && n >= days_before_month(leap, mon)) begin
            mon++;
        end
        r.year         = YEAR_W'(q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1);
        r.month        = MONTH_W'(mon);
        r.day_of_month = DOM_W'(n - days_before_month(leap, mon - 1) + 1);
        r.day_of_year  = DOY_W'(n + 1);
        r.hour         = HOUR_W'(tod / 3_600_000);
        r.minute       = MINUTE_W'((tod / 60_000) % 60);
        r.second       = SECOND_W'((tod / 1_000) % 60);
        r.millisecond  = MS_W'(tod % 1_000);
        r.leap_year    = leap;
        return r;
    endfunction

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    // tick count of a date given as year, zero-based day of year and ms of day
    function automatic logic [TICK_W-1:0] tick_at(input int unsigned y, input int unsigned doy0,
                                                  input longint unsigned tod);
        longint unsigned yb;
        yb = 64'(y) - 1;
        return TICK_W'((yb * 365 + yb / 4 - yb / 100 + yb / 400 + doy0) * MS_DAY + tod);
    endfunction

    function automatic logic [TICK_W-1:0] random_tick();
        int unsigned     sel;
        int unsigned     y;
        int unsigned     doy0;
        int unsigned     ylen;
        longint unsigned tod;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return TICK_W'({$urandom, $urandom});
        end
        if (sel == 1) begin
            return TICK_W'(DAY_COUNT * MS_DAY - 2 * MS_DAY + $urandom_range(0, 345_600_000));
        end
        if ($urandom_range(0, 3) == 0) begin
            y = 100 * $urandom_range(1, 99) + $urandom_range(0, 1) - 1;
        end else begin
            y = $urandom_range(1, MAX_YEAR);
        end
        ylen = is_leap(y) ? 366 : 365;
        case ($urandom_range(0, 7))
            0:       doy0 = 0;
            1:       doy0 = ylen - 1;
            default: doy0 = $urandom_range(0, ylen - 1);
        endcase
        case ($urandom_range(0, 7))
            0:       tod = 0;
            1:       tod = MS_DAY - 1;
            default: tod = 64'($urandom_range(0, int'(MS_DAY) - 1));
        endcase
        return tick_at(y, doy0, tod);
    endfunction

    task automatic offer_tick(input logic [TICK_W-1:0] ticks);
        int unsigned gap;
        gap = 0;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_tick_count <= ticks;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_dates.push_back(calendar_of(ticks));
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_date();
        t_cal want;
        if (pending_dates.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
            return;
        end
        want = pending_dates.pop_front();
        compare_field("year", 64'(want.year), 64'(o_year));
        compare_field("month", 64'(want.month), 64'(o_month));
        compare_field("day_of_month", 64'(want.day_of_month), 64'(o_day_of_month));
        compare_field("day_of_year", 64'(want.day_of_year), 64'(o_day_of_year));
        compare_field("hour", 64'(want.hour), 64'(o_hour));
        compare_field("minute", 64'(want.minute), 64'(o_minute));
        compare_field("second", 64'(want.second), 64'(o_second));
        compare_field("millisecond", 64'(want.millisecond), 64'(o_millisecond));
        compare_field("leap_year", 64'(want.leap_year), 64'(o_leap_year));
        compare_field("out_of_range", 64'(want.out_of_range), 64'(o_out_of_range));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_date();
        end
        if (hold_seen != hold_token) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tick_count_to_calendar");
            $finish;
        end
    end

    task automatic test_boundaries();
        offer_tick('0);
        offer_tick(TICK_W'(MS_DAY - 1));
        offer_tick(tick_at(1, 31, 43_200_000));
        offer_tick(tick_at(4, 59, 0));
        offer_tick(tick_at(4, 365, MS_DAY - 1));
        offer_tick(tick_at(5, 0, 0));
        offer_tick(tick_at(100, 364, MS_DAY - 1));
        offer_tick(tick_at(101, 0, 0));
        offer_tick(tick_at(400, 365, MS_DAY - 1));
        offer_tick(tick_at(401, 0, 1));
        offer_tick(tick_at(1900, 59, 0));
        offer_tick(tick_at(2000, 59, 0));
        offer_tick(tick_at(2000, 365, 45_296_789));
        offer_tick(tick_at(2024, 334, 3_599_999));
        offer_tick(tick_at(MAX_YEAR, 0, 0));
        offer_tick(TICK_W'(LAST_TICK));
        offer_tick(TICK_W'(LAST_TICK + 1));
        offer_tick(TICK_W'(LAST_TICK + MS_DAY));
        offer_tick('1);
        offer_tick(TICK_W'({(TICK_W + 1) / 2{2'b10}}));
        offer_tick(TICK_W'({(TICK_W + 1) / 2{2'b01}}));
    endtask

    task automatic test_random_dates(input int unsigned count);
        repeat (count) offer_tick(random_tick());
    endtask

    // receiver stops while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        hold_token <= hold_token + 1;
        repeat (6) offer_tick(random_tick());
    endtask

    task automatic test_full_rate(input int unsigned count);
        bursts_on = 1'b0;
        repeat (count) offer_tick(random_tick());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_boundaries();
        test_random_dates(900);
        test_output_hold();
        test_full_rate(320);
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS tick_count_to_calendar");
        end else begin
            $display("FAIL tick_count_to_calendar");
        end
        $finish;
    end

endmodule
